FILE: sv/decaying_load_latency_monitor_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the decaying load latency monitor
// Concurrent property wrappers used by the monitor checker.
// ---------------------------------------------------------------------------
`ifndef DECAYING_LOAD_LATENCY_MONITOR_MACROS_SVH
`define DECAYING_LOAD_LATENCY_MONITOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLLM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLLM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dllm_pkg.sv
// ---------------------------------------------------------------------------
// Decaying load latency monitor package
// Payload types, widths, decay and saturation helpers.
// ---------------------------------------------------------------------------
package dllm_pkg;

    localparam int ACC_W      = 32;
    localparam int CNT16_W    = 16;
    localparam int GAP_W      = 4;
    localparam int MUL_B_W    = CNT16_W + 2;
    localparam int MUL_STEPS  = MUL_B_W;
    localparam int QUO_W      = ACC_W - 2;
    localparam int DIV_STEPS  = QUO_W;
    localparam int STEP_CNT_W = 5;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] MAX_GAP = ACC_W'(8);

    // Configuration register indexes.
    localparam logic CFG_TARGET_AVG  = 1'b0;
    localparam logic CFG_TARGET_PEAK = 1'b1;

    typedef struct packed {
        logic [ACC_W-1:0]   now_seconds;
        logic [CNT16_W-1:0] work_count;
        logic               latency_valid;
        logic [CNT16_W-1:0] latency_ms;
    } dllm_in_t;

    typedef struct packed {
        logic [ACC_W-1:0] load_count;
        logic [ACC_W-1:0] avg_latency;
        logic [ACC_W-1:0] peak_latency;
        logic             over_target;
    } dllm_out_t;

    // Handshake between the sequencer and a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } dllm_unit_stat_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    // Removes ceil(x/4).
    function automatic logic [ACC_W-1:0] decay_up(input logic [ACC_W-1:0] x);
        return x - (x >> 2) - ACC_W'(|x[1:0]);
    endfunction

    // Removes floor(x/4).
    function automatic logic [ACC_W-1:0] decay_down(input logic [ACC_W-1:0] x);
        return x - (x >> 2);
    endfunction

endpackage

FILE: sv/dllm_mul.sv
// ---------------------------------------------------------------------------
// Serial saturating multiplier
// Shift-and-add over one multiplier bit per cycle, MSB first; the product
// clamps to the accumulator maximum.
// ---------------------------------------------------------------------------
module dllm_mul
    import dllm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [ACC_W-1:0]      a_in,
    input  logic [MUL_B_W-1:0]    b_in,
    output dllm_unit_stat_t       stat,
    output logic [ACC_W-1:0]      prod
);

    logic [ACC_W-1:0]      a_reg, a_next;
    logic [MUL_B_W-1:0]    b_reg, b_next;
    logic [ACC_W-1:0]      p_reg, p_next;
    logic                  sat_reg, sat_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ACC_W+1:0]      sum;

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sum = {1'b0, p_reg, 1'b0} + {2'b00, (b_reg[MUL_B_W-1] ? a_reg : '0)};
        if (start) begin
            a_next    = a_in;
            b_next    = b_in;
            p_next    = '0;
            sat_next  = 1'b0;
            cnt_next  = STEP_CNT_W'(MUL_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // The partial product only grows, so clamping early is exact.
            p_next   = sum[ACC_W-1:0];
            sat_next = sat_reg | (|sum[ACC_W+1:ACC_W]);
            b_next   = {b_reg[MUL_B_W-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        p_reg   <= p_next;
        sat_reg <= sat_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = sat_reg ? ACC_MAX : p_reg;

endmodule

FILE: sv/dllm_div.sv
// ---------------------------------------------------------------------------
// Serial two-lane divider
// Restoring division, one quotient bit per cycle, of two dividends by a
// shared divisor.
// ---------------------------------------------------------------------------
module dllm_div
    import dllm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [QUO_W-1:0]      num_a,
    input  logic [QUO_W-1:0]      num_b,
    input  logic [ACC_W-1:0]      den,
    output dllm_unit_stat_t       stat,
    output logic [QUO_W-1:0]      quo_a,
    output logic [QUO_W-1:0]      quo_b
);

    logic [1:0][QUO_W-1:0] n_reg, n_next;
    logic [1:0][ACC_W-1:0] r_reg, r_next;
    logic [ACC_W-1:0]      d_reg, d_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [1:0][ACC_W:0]   r_sh;
    logic [1:0]            ge;

    always_comb begin
        n_next    = n_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        for (int i = 0; i < 2; i++) begin
            r_sh[i] = {r_reg[i], n_reg[i][QUO_W-1]};
            ge[i]   = r_sh[i] >= {1'b0, d_reg};
        end
        if (start) begin
            n_next[0] = num_a;
            n_next[1] = num_b;
            r_next    = '0;
            d_next    = den;
            cnt_next  = STEP_CNT_W'(DIV_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so it fits ACC_W bits.
            for (int i = 0; i < 2; i++) begin
                r_next[i] = ge[i] ? ACC_W'(r_sh[i] - {1'b0, d_reg}) : r_sh[i][ACC_W-1:0];
                n_next[i] = {n_reg[i][QUO_W-2:0], ge[i]};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        n_reg <= n_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo_a     = n_reg[0];
    assign quo_b     = n_reg[1];

endmodule

FILE: sv/decaying_load_latency_monitor.sv
// ---------------------------------------------------------------------------
// Decaying load latency monitor
// Ages load and latency accumulators per second, folds in each transaction
// and reports load, average and peak latency and an over-target flag.
// ---------------------------------------------------------------------------
//  channel  ports                         direction  payload
//  s        s_valid s_ready s_data        in         dllm_in_t
//  m        m_valid m_ready m_data        out        dllm_out_t
//  cfg      cfg_we cfg_index cfg_wdata    in         16-bit target register
//
// One transaction at a time; the time it takes is set by the decay loop
// (gap <= 8), the bit-serial multiplier, which runs only with a latency
// sample, and the bit-serial divider, which runs only when the event count
// is nonzero.
// Reset is synchronous and active low and clears all accumulators and targets.
// A finished result waits in the output register; a new transaction is taken
// meanwhile and is held at its last step until the output register frees.
// ---------------------------------------------------------------------------
module decaying_load_latency_monitor
    import dllm_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dllm_in_t        s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dllm_out_t       m_data,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [15:0]     cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_AGE   = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_DIVS  = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    logic [2:0]         state_reg, state_next;
    dllm_in_t           in_reg, in_next;
    logic [ACC_W-1:0]   last_reg, last_next;
    logic [ACC_W-1:0]   count_reg, count_next;
    logic [ACC_W-1:0]   event_reg, event_next;
    logic [ACC_W-1:0]   sum_reg, sum_next;
    logic [ACC_W-1:0]   peak_reg, peak_next;
    logic [GAP_W-1:0]   gap_reg, gap_next;
    logic [CNT16_W-1:0] tavg_reg, tavg_next;
    logic [CNT16_W-1:0] tpeak_reg, tpeak_next;
    logic               m_valid_reg, m_valid_next;
    dllm_out_t          m_data_reg, m_data_next;

    logic [ACC_W-1:0]   diff;
    logic [CNT16_W-1:0] lat_eff;
    logic [ACC_W-1:0]   ev_inc;
    logic [ACC_W-1:0]   avg_val;
    logic [ACC_W-1:0]   peak_val;

    logic               mul_start;
    dllm_unit_stat_t    mul_stat;
    logic [ACC_W-1:0]   mul_prod;
    logic               div_start;
    dllm_unit_stat_t    div_stat;
    logic [QUO_W-1:0]   quo_avg;
    logic [QUO_W-1:0]   quo_peak;

    dllm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (ev_inc),
        .b_in    ({lat_eff, 2'b00}),
        .stat    (mul_stat),
        .prod    (mul_prod)
    );

    // floor(x / (4e)) equals floor(floor(x/4) / e).
    dllm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_a   (sum_reg[ACC_W-1:2]),
        .num_b   (peak_reg[ACC_W-1:2]),
        .den     (event_reg),
        .stat    (div_stat),
        .quo_a   (quo_avg),
        .quo_b   (quo_peak)
    );

    assign diff    = in_reg.now_seconds - last_reg;
    assign lat_eff = (in_reg.latency_ms == CNT16_W'(1)) ? '0 : in_reg.latency_ms;
    assign ev_inc  = sat_add(event_reg, ACC_W'(1));

    always_comb begin
        if (event_reg == '0) begin
            avg_val  = '0;
            peak_val = '0;
        end else begin
            avg_val  = {2'b00, quo_avg};
            peak_val = {2'b00, quo_peak};
        end
    end

    always_comb begin
        state_next   = state_reg;
        in_next      = in_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        event_next   = event_reg;
        sum_next     = sum_reg;
        peak_next    = peak_reg;
        gap_next     = gap_reg;
        tavg_next    = tavg_reg;
        tpeak_next   = tpeak_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        mul_start    = 1'b0;
        div_start    = 1'b0;

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_TARGET_AVG:  tavg_next  = cfg_wdata;
                CFG_TARGET_PEAK: tpeak_next = cfg_wdata;
                default:         tavg_next  = tavg_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                last_next = in_reg.now_seconds;
                if (in_reg.now_seconds == last_reg) begin
                    state_next = ST_ADD;
                end else if (in_reg.now_seconds < last_reg || diff > MAX_GAP) begin
                    count_next = '0;
                    event_next = '0;
                    sum_next   = '0;
                    peak_next  = '0;
                    state_next = ST_ADD;
                end else begin
                    gap_next   = diff[GAP_W-1:0];
                    state_next = ST_AGE;
                end
            end
            ST_AGE: begin
                count_next = decay_up(count_reg);
                event_next = decay_up(event_reg);
                sum_next   = decay_down(sum_reg);
                peak_next  = decay_down(peak_reg);
                gap_next   = gap_reg - 1'b1;
                if (gap_reg == GAP_W'(1)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                count_next = sat_add(count_reg, ACC_W'(in_reg.work_count));
                if (in_reg.latency_valid) begin
                    event_next = ev_inc;
                    sum_next   = sat_add(sum_reg, ACC_W'(lat_eff));
                    peak_next  = sat_add(peak_reg, ACC_W'(lat_eff));
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_DIVS;
                end
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    if (peak_reg < mul_prod) begin
                        peak_next = mul_prod;
                    end
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS: begin
                if (event_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.load_count   = count_reg >> 2;
                    m_data_next.avg_latency  = avg_val;
                    m_data_next.peak_latency = peak_val;
                    m_data_next.over_target  =
                        (tpeak_reg != '0 && peak_val > ACC_W'(tpeak_reg)) ||
                        (tavg_reg != '0 && avg_val > ACC_W'(tavg_reg));
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            last_reg    <= '0;
            count_reg   <= '0;
            event_reg   <= '0;
            sum_reg     <= '0;
            peak_reg    <= '0;
            gap_reg     <= '0;
            tavg_reg    <= '0;
            tpeak_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            count_reg   <= count_next;
            event_reg   <= event_next;
            sum_reg     <= sum_next;
            peak_reg    <= peak_next;
            gap_reg     <= gap_next;
            tavg_reg    <= tavg_next;
            tpeak_reg   <= tpeak_next;
            m_valid_reg <= m_valid_next;
        end
        in_reg     <= in_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: sv/dllm_checker.sv
// ---------------------------------------------------------------------------
// Decaying load latency monitor checker
// Port-level properties of the monitor, bound to the top level.
// ---------------------------------------------------------------------------
`include "decaying_load_latency_monitor_macros.svh"

module dllm_checker
    import dllm_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input dllm_out_t   m_data
);

    // A stalled result holds its value.
    `DLLM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // Only one transaction is in work at a time.
    `DLLM_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while busy")

    // A result never appears in the cycle right after an input is taken.
    `DLLM_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_valid && s_ready, !$rose(m_valid), "result too early")

    // Zero latencies can never exceed a target.
    `DLLM_ASSERT_NOW(a_zero_not_over, aclk, aresetn, m_valid && m_data.avg_latency == '0 && m_data.peak_latency == '0, !m_data.over_target, "over flag with zero latency")

endmodule

bind decaying_load_latency_monitor dllm_checker u_dllm_checker (.*);

FILE: dv/decaying_load_latency_monitor_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decaying load latency monitor testbench
// Sends timed work and latency transactions through the block, predicts each
// report from its own copy of the aging accumulators and compares every
// returned report field by field, under random idling and back-pressure.
// ---------------------------------------------------------------------------
module decaying_load_latency_monitor_tb;
    import dllm_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    dllm_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    dllm_out_t m_data;
    logic      cfg_we = 1'b0;
    logic      cfg_index = CFG_TARGET_AVG;
    logic [15:0] cfg_wdata = '0;

    dllm_in_t  sample_q[$];
    dllm_out_t report_q[$];
    dllm_out_t want;

    int n_queued = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_err = 0;
    int hold_left = 0;

    // Predictor copy of the block's state and targets.
    logic [31:0] acc_sec = '0;
    logic [31:0] acc_load = '0;
    logic [31:0] acc_events = '0;
    logic [31:0] acc_lat_sum = '0;
    logic [31:0] acc_lat_peak = '0;
    logic [15:0] tgt_avg = '0;
    logic [15:0] tgt_peak = '0;

    decaying_load_latency_monitor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // One second of aging for the load and event counts drops ceil(x/4).
    function automatic logic [31:0] shed_ceil(input logic [31:0] x);
        return x - (x >> 2) - {31'b0, x[1:0] != 2'b00};
    endfunction

    function automatic dllm_out_t predict_report(input dllm_in_t it);
        logic [31:0] gap;
        logic [15:0] lat;
        logic [63:0] prod;
        logic [63:0] div;
        dllm_out_t   rep;
        rep = '0;
        if (it.now_seconds != acc_sec) begin
            if (it.now_seconds < acc_sec || it.now_seconds - acc_sec > MAX_GAP) begin
                acc_load     = '0;
                acc_events   = '0;
                acc_lat_sum  = '0;
                acc_lat_peak = '0;
            end else begin
                gap = it.now_seconds - acc_sec;
                for (int i = 0; i < gap; i++) begin
                    acc_load     = shed_ceil(acc_load);
                    acc_events   = shed_ceil(acc_events);
                    acc_lat_sum  = acc_lat_sum - (acc_lat_sum >> 2);
                    acc_lat_peak = acc_lat_peak - (acc_lat_peak >> 2);
                end
            end
            acc_sec = it.now_seconds;
        end
        acc_load = sat_sum(acc_load, {16'b0, it.work_count});
        if (it.latency_valid) begin
            lat = (it.latency_ms == 16'd1) ? 16'd0 : it.latency_ms;
            acc_events   = sat_sum(acc_events, 32'd1);
            acc_lat_sum  = sat_sum(acc_lat_sum, {16'b0, lat});
            acc_lat_peak = sat_sum(acc_lat_peak, {16'b0, lat});
            prod = 64'(acc_events) * (64'(lat) << 2);
            if (prod > 64'(ACC_MAX))
                prod = 64'(ACC_MAX);
            if (64'(acc_lat_peak) < prod)
                acc_lat_peak = prod[31:0];
        end
        if (acc_events != 0) begin
            div = 64'(acc_events) << 2;
            rep.avg_latency  = 32'(64'(acc_lat_sum) / div);
            rep.peak_latency = 32'(64'(acc_lat_peak) / div);
        end
        rep.load_count  = acc_load >> 2;
        rep.over_target = (tgt_peak != 0 && rep.peak_latency > {16'b0, tgt_peak}) ||
                          (tgt_avg != 0 && rep.avg_latency > {16'b0, tgt_avg});
        return rep;
    endfunction

    task automatic queue_sample(input logic [31:0] now, input logic [15:0] work,
                                input logic valid, input logic [15:0] lat);
        dllm_in_t it;
        it.now_seconds   = now;
        it.work_count    = work;
        it.latency_valid = valid;
        it.latency_ms    = lat;
        sample_q.push_back(it);
        n_queued++;
    endtask

    task automatic write_target(input logic idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_TARGET_AVG)
            tgt_avg = val;
        else
            tgt_peak = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued transaction has reported, then lets the block settle.
    task automatic wait_drained();
        while (n_recv != n_queued)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Driver: offers queued samples, predicts each one when it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                report_q.push_back(predict_report(s_data));
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (sample_q.size() != 0 &&
                    ((n_sent >= 300 && n_sent < 420) || $urandom_range(0, 99) >= 23)) begin
                    s_data  <= sample_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted report against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    $error("report received with no transaction outstanding");
                    n_err++;
                end else begin
                    want = report_q.pop_front();
                    if (m_data.load_count !== want.load_count) begin
                        $error("load_count expected %0d, got %0d",
                               want.load_count, m_data.load_count);
                        n_err++;
                    end
                    if (m_data.avg_latency !== want.avg_latency) begin
                        $error("avg_latency expected %0d, got %0d",
                               want.avg_latency, m_data.avg_latency);
                        n_err++;
                    end
                    if (m_data.peak_latency !== want.peak_latency) begin
                        $error("peak_latency expected %0d, got %0d",
                               want.peak_latency, m_data.peak_latency);
                        n_err++;
                    end
                    if (m_data.over_target !== want.over_target) begin
                        $error("over_target expected %0d, got %0d",
                               want.over_target, m_data.over_target);
                        n_err++;
                    end
                end
                n_recv++;
                // A long hold-off so the block fills up and stops taking input.
                if (n_recv == 140)
                    hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (n_recv >= 300 && n_recv < 420) || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    initial begin : stimulus
        logic [31:0] gnow;
        logic [15:0] gwork;
        logic [15:0] glat;
        logic        gvalid;
        int          r;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        write_target(CFG_TARGET_AVG, 16'd2000);
        write_target(CFG_TARGET_PEAK, 16'd30000);

        // Directed part, starting from the reset second.
        queue_sample(32'd0, 16'd0, 1'b0, 16'd0);
        queue_sample(32'd0, 16'hFFFF, 1'b1, 16'hFFFF);
        queue_sample(32'd0, 16'hFFFF, 1'b1, 16'd1);
        queue_sample(32'd0, 16'd0, 1'b1, 16'd0);
        queue_sample(32'd1, 16'd100, 1'b1, 16'd500);
        queue_sample(32'd9, 16'd3, 1'b0, 16'd0);
        queue_sample(32'd18, 16'd9, 1'b1, 16'd2);
        queue_sample(32'd5, 16'd7, 1'b0, 16'd0);
        queue_sample(32'd5, 16'd0, 1'b0, 16'hFFFF);
        queue_sample(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'd40000);
        queue_sample(32'hFFFF_FFFF, 16'd1, 1'b1, 16'd1);
        queue_sample(32'd0, 16'h5555, 1'b1, 16'hAAAA);
        queue_sample(32'd3, 16'd12, 1'b1, 16'd7);
        queue_sample(32'd7, 16'd0, 1'b0, 16'd0);
        queue_sample(32'hFFFF_FFF8, 16'hAAAA, 1'b1, 16'h5555);
        queue_sample(32'hFFFF_FFFF, 16'd0, 1'b1, 16'hFFFF);
        queue_sample(32'hFFFF_FFFF, 16'd0, 1'b0, 16'd0);

        gnow = 32'd100;
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_target(CFG_TARGET_AVG, 16'd0);
                    write_target(CFG_TARGET_PEAK, 16'd0);
                end
                1: begin
                    write_target(CFG_TARGET_AVG, 16'hFFFF);
                    write_target(CFG_TARGET_PEAK, 16'hFFFF);
                end
                2: begin
                    write_target(CFG_TARGET_AVG, 16'd1);
                    write_target(CFG_TARGET_PEAK, 16'd1);
                end
                3: begin
                    write_target(CFG_TARGET_AVG, 16'd0);
                    write_target(CFG_TARGET_PEAK, 16'($urandom_range(1, 65535)));
                end
                4: begin
                    write_target(CFG_TARGET_AVG, 16'($urandom_range(1, 16383)));
                    write_target(CFG_TARGET_PEAK, 16'd0);
                end
                5: begin
                    write_target(CFG_TARGET_AVG, 16'($urandom_range(0, 4000)));
                    write_target(CFG_TARGET_PEAK, 16'($urandom_range(0, 20000)));
                end
                6: begin
                    write_target(CFG_TARGET_AVG, 16'($urandom));
                    write_target(CFG_TARGET_PEAK, 16'($urandom));
                end
                default: begin
                    write_target(CFG_TARGET_AVG, 16'($urandom_range(1, 2000)));
                    write_target(CFG_TARGET_PEAK, 16'($urandom_range(1, 8000)));
                end
            endcase
            for (int k = 0; k < 80; k++) begin
                // Mostly short forward steps that keep the accumulators aging;
                // the rest are long jumps, backward steps and arbitrary times.
                r = $urandom_range(0, 99);
                if (r < 72)
                    gnow = gnow + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
                else if (r < 80)
                    gnow = gnow + $urandom_range(9, 5000);
                else if (r < 87)
                    gnow = gnow - $urandom_range(1, 50);
                else
                    gnow = $urandom();
                r = $urandom_range(0, 9);
                gwork = (r < 2) ? 16'd0 : (r == 2) ? 16'hFFFF : 16'($urandom);
                gvalid = ($urandom_range(0, 9) < 6);
                r = $urandom_range(0, 19);
                if (r < 2)
                    glat = 16'd1;
                else if (r == 2)
                    glat = 16'd0;
                else if (r == 3)
                    glat = 16'hFFFF;
                else if (r < 12)
                    glat = 16'($urandom);
                else
                    glat = 16'($urandom_range(0, 2000));
                queue_sample(gnow, gwork, gvalid, glat);
            end
        end

        wait_drained();
        if (report_q.size() != 0) begin
            $error("%0d predicted reports never arrived", report_q.size());
            n_err++;
        end
        if (n_err == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
